FILE: design/spdg_pkg.sv
// shared constants and types for the dense-graph shortest path engine
package spdg_pkg;

  localparam int MAX_NODE_COUNT = 64;
  localparam int NODE_BITS      = 6;
  localparam int COUNT_BITS     = 7;
  localparam int WEIGHT_BITS    = 16;
  localparam int DIST_BITS      = 22;
  localparam int ADJ_ADDR_BITS  = 2 * NODE_BITS;
  localparam int ADJ_DEPTH      = 1 << ADJ_ADDR_BITS;
  localparam int IN_DATA_BITS   = 32;
  localparam int OUT_DATA_BITS  = 24;

  localparam logic [DIST_BITS-1:0] DIST_INF = '1;
  localparam logic [DIST_BITS-1:0] DIST_SAT = {{(DIST_BITS-1){1'b1}}, 1'b0};

  typedef enum logic [1:0] {
    OP_EDGE  = 2'd0,
    OP_QUERY = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EDGE2,
    ST_INIT,
    ST_NEXT,
    ST_PICK,
    ST_MARK,
    ST_RELAX,
    ST_READ,
    ST_DONE
  } state_t;

endpackage

FILE: design/shortest_path_dense_graph.sv
// dijkstra shortest path engine over a dense adjacency matrix memory
//
//  channel | ports                          | contents
//  --------+--------------------------------+----------------------------------
//  in      | in_tvalid/in_tready/in_tdata   | opcode, node_a, node_b, weight
//  out     | out_tvalid/out_tready/out_tdata| path_distance, reachable, bad_node
//  cfg     | cfg_wr_en/cfg_wr_data          | node_count
//
// edge write: one adjacency memory write port, so both directions are written one after the other
// clear: one matrix entry per cycle over all 4096 entries; reset runs the same pass
// query with n nodes: paced by the single distance memory read port, which scans
//   n entries per min search and relax
// in_tready is low while an item is in work or a result waits in the output reg
//   and is not taken

module shortest_path_dense_graph (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [spdg_pkg::COUNT_BITS-1:0]      cfg_wr_data,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // [1:0] opcode, [7:2] node_a, [13:8] node_b, [29:14] edge_weight, [31:30] zero
  input  logic [spdg_pkg::IN_DATA_BITS-1:0]    in_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // [21:0] path_distance, [22] reachable, [23] bad_node
  output logic [spdg_pkg::OUT_DATA_BITS-1:0]   out_tdata
);

  localparam int NB = spdg_pkg::NODE_BITS;
  localparam int CB = spdg_pkg::COUNT_BITS;
  localparam int WB = spdg_pkg::WEIGHT_BITS;
  localparam int DB = spdg_pkg::DIST_BITS;
  localparam int AB = spdg_pkg::ADJ_ADDR_BITS;

  spdg_pkg::state_t state_r, state_nxt;

  logic [CB-1:0] node_count_r;
  logic [CB-1:0] n_act;

  logic [AB-1:0] clr_r, clr_nxt;
  logic [CB-1:0] cnt_r, cnt_nxt;
  logic [CB-1:0] round_r, round_nxt;
  logic [DB-1:0] best_r, best_nxt;
  logic [NB-1:0] best_idx_r, best_idx_nxt;
  logic          pipe_vld_r, pipe_vld_nxt;
  logic [NB-1:0] pipe_idx_r, pipe_idx_nxt;
  logic [NB-1:0] a_r, a_nxt, b_r, b_nxt;
  logic [WB-1:0] w_r, w_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [DB-1:0] out_dist_r, out_dist_nxt;
  logic          out_reach_r, out_reach_nxt;
  logic          out_bad_r, out_bad_nxt;

  // memories
  logic [WB-1:0] adj_mem [spdg_pkg::ADJ_DEPTH];
  logic          adj_we;
  logic [AB-1:0] adj_waddr, adj_raddr;
  logic [WB-1:0] adj_wdata, adj_rdata_r;

  // each entry holds {visited mark, distance}
  logic [DB:0]   dist_mem [spdg_pkg::MAX_NODE_COUNT];
  logic          dist_we;
  logic [NB-1:0] dist_waddr, dist_raddr;
  logic [DB:0]   dist_wdata, dist_rdata_r;

  // input decode
  spdg_pkg::opcode_t in_op;
  logic [NB-1:0] in_a, in_b;
  logic [WB-1:0] in_w;
  logic          in_accept, in_bad, out_free;

  // relax datapath
  logic [DB:0]   sum;
  logic [DB-1:0] cand;
  logic          relax_hit, pick_hit;

  assign in_op     = spdg_pkg::opcode_t'(in_tdata[1:0]);
  assign in_a      = in_tdata[7:2];
  assign in_b      = in_tdata[13:8];
  assign in_w      = in_tdata[29:14];
  assign n_act     = (node_count_r > CB'(spdg_pkg::MAX_NODE_COUNT))
                     ? CB'(spdg_pkg::MAX_NODE_COUNT) : node_count_r;
  assign in_bad    = ({1'b0, in_a} >= n_act) || ({1'b0, in_b} >= n_act);
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == spdg_pkg::ST_IDLE) && out_free;
  assign in_accept = in_tvalid && in_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_bad_r, out_reach_r, out_dist_r};

  // add / saturate / compare unit of the relax step
  assign sum  = {1'b0, best_r} + {{(DB+1-WB){1'b0}}, adj_rdata_r};
  assign cand = (sum > {1'b0, spdg_pkg::DIST_SAT}) ? spdg_pkg::DIST_SAT : sum[DB-1:0];
  assign relax_hit = (state_r == spdg_pkg::ST_RELAX) && pipe_vld_r &&
                     !dist_rdata_r[DB] && (adj_rdata_r != '0) &&
                     (cand < dist_rdata_r[DB-1:0]);
  // ties go to the later index
  assign pick_hit  = (state_r == spdg_pkg::ST_PICK) && pipe_vld_r &&
                     !dist_rdata_r[DB] && (dist_rdata_r[DB-1:0] <= best_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      spdg_pkg::ST_CLEAR: begin
        if (clr_r == '1) state_nxt = spdg_pkg::ST_IDLE;
      end
      spdg_pkg::ST_IDLE: begin
        if (in_accept) begin
          case (in_op)
            spdg_pkg::OP_EDGE:  if (!in_bad) state_nxt = spdg_pkg::ST_EDGE2;
            spdg_pkg::OP_QUERY: if (!in_bad) state_nxt = spdg_pkg::ST_INIT;
            spdg_pkg::OP_CLEAR: state_nxt = spdg_pkg::ST_CLEAR;
            default:            state_nxt = spdg_pkg::ST_IDLE;
          endcase
        end
      end
      spdg_pkg::ST_EDGE2: state_nxt = spdg_pkg::ST_IDLE;
      spdg_pkg::ST_INIT: begin
        if (cnt_r == n_act - CB'(1)) state_nxt = spdg_pkg::ST_NEXT;
      end
      spdg_pkg::ST_NEXT: begin
        if (({1'b0, round_r} + (CB+1)'(1)) < {1'b0, n_act}) state_nxt = spdg_pkg::ST_PICK;
        else state_nxt = spdg_pkg::ST_READ;
      end
      spdg_pkg::ST_PICK: begin
        if (cnt_r == n_act) state_nxt = spdg_pkg::ST_MARK;
      end
      spdg_pkg::ST_MARK: begin
        // an unreachable pick relaxes nothing
        if (best_r == spdg_pkg::DIST_INF) state_nxt = spdg_pkg::ST_NEXT;
        else state_nxt = spdg_pkg::ST_RELAX;
      end
      spdg_pkg::ST_RELAX: begin
        if (cnt_r == n_act) state_nxt = spdg_pkg::ST_NEXT;
      end
      spdg_pkg::ST_READ: state_nxt = spdg_pkg::ST_DONE;
      spdg_pkg::ST_DONE: begin
        if (out_free) state_nxt = spdg_pkg::ST_IDLE;
      end
      default: state_nxt = spdg_pkg::ST_IDLE;
    endcase
  end

  // datapath and output controls
  always_comb begin
    clr_nxt       = clr_r;
    cnt_nxt       = cnt_r;
    round_nxt     = round_r;
    best_nxt      = best_r;
    best_idx_nxt  = best_idx_r;
    pipe_vld_nxt  = 1'b0;
    pipe_idx_nxt  = cnt_r[NB-1:0];
    a_nxt         = a_r;
    b_nxt         = b_r;
    w_nxt         = w_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_dist_nxt  = out_dist_r;
    out_reach_nxt = out_reach_r;
    out_bad_nxt   = out_bad_r;

    adj_we     = 1'b0;
    adj_waddr  = clr_r;
    adj_wdata  = '0;
    adj_raddr  = {best_idx_r, cnt_r[NB-1:0]};
    dist_we    = 1'b0;
    dist_waddr = cnt_r[NB-1:0];
    dist_wdata = {1'b0, spdg_pkg::DIST_INF};
    dist_raddr = cnt_r[NB-1:0];

    case (state_r)
      spdg_pkg::ST_CLEAR: begin
        adj_we  = 1'b1;
        clr_nxt = clr_r + AB'(1);
      end
      spdg_pkg::ST_IDLE: begin
        if (in_accept) begin
          a_nxt       = in_a;
          b_nxt       = in_b;
          w_nxt       = in_w;
          cnt_nxt     = '0;
          round_nxt   = '0;
          clr_nxt     = '0;
          if ((in_op == spdg_pkg::OP_EDGE || in_op == spdg_pkg::OP_QUERY) && in_bad) begin
            out_valid_nxt = 1'b1;
            out_dist_nxt  = spdg_pkg::DIST_INF;
            out_reach_nxt = 1'b0;
            out_bad_nxt   = 1'b1;
          end
          if (in_op == spdg_pkg::OP_EDGE && !in_bad) begin
            adj_we    = 1'b1;
            adj_waddr = {in_a, in_b};
            adj_wdata = in_w;
          end
        end
      end
      spdg_pkg::ST_EDGE2: begin
        adj_we    = 1'b1;
        adj_waddr = {b_r, a_r};
        adj_wdata = w_r;
      end
      spdg_pkg::ST_INIT: begin
        // init also clears the visited mark of each entry
        dist_we    = 1'b1;
        dist_wdata = (cnt_r[NB-1:0] == a_r) ? {1'b0, {DB{1'b0}}}
                                            : {1'b0, spdg_pkg::DIST_INF};
        cnt_nxt    = cnt_r + CB'(1);
      end
      spdg_pkg::ST_NEXT: begin
        cnt_nxt      = '0;
        best_nxt     = spdg_pkg::DIST_INF;
        best_idx_nxt = '0;
        round_nxt    = round_r + CB'(1);
      end
      spdg_pkg::ST_PICK, spdg_pkg::ST_RELAX: begin
        if (cnt_r < n_act) begin
          cnt_nxt      = cnt_r + CB'(1);
          pipe_vld_nxt = 1'b1;
        end
        if (pick_hit) begin
          best_nxt     = dist_rdata_r[DB-1:0];
          best_idx_nxt = pipe_idx_r;
        end
        if (relax_hit) begin
          dist_we    = 1'b1;
          dist_waddr = pipe_idx_r;
          dist_wdata = {1'b0, cand};
        end
      end
      spdg_pkg::ST_MARK: begin
        dist_we    = 1'b1;
        dist_waddr = best_idx_r;
        dist_wdata = {1'b1, best_r};
        cnt_nxt    = '0;
      end
      spdg_pkg::ST_READ: begin
        dist_raddr = b_r;
      end
      spdg_pkg::ST_DONE: begin
        dist_raddr = b_r;
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_dist_nxt  = dist_rdata_r[DB-1:0];
          out_reach_nxt = (dist_rdata_r[DB-1:0] != spdg_pkg::DIST_INF);
          out_bad_nxt   = 1'b0;
        end
      end
      default: begin
        cnt_nxt = cnt_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= spdg_pkg::ST_CLEAR;
      node_count_r <= CB'(spdg_pkg::MAX_NODE_COUNT);
      clr_r        <= '0;
      pipe_vld_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      pipe_vld_r  <= pipe_vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) node_count_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r       <= cnt_nxt;
    round_r     <= round_nxt;
    best_r      <= best_nxt;
    best_idx_r  <= best_idx_nxt;
    pipe_idx_r  <= pipe_idx_nxt;
    a_r         <= a_nxt;
    b_r         <= b_nxt;
    w_r         <= w_nxt;
    out_dist_r  <= out_dist_nxt;
    out_reach_r <= out_reach_nxt;
    out_bad_r   <= out_bad_nxt;
  end

  always_ff @(posedge clk) begin
    if (adj_we) adj_mem[adj_waddr] <= adj_wdata;
    adj_rdata_r <= adj_mem[adj_raddr];
  end

  always_ff @(posedge clk) begin
    if (dist_we) dist_mem[dist_waddr] <= dist_wdata;
    dist_rdata_r <= dist_mem[dist_raddr];
  end

  // checks
  a_bad_no_reach: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_bad_r |-> !out_reach_r && (out_dist_r == spdg_pkg::DIST_INF))
    else $error("bad node result with distance or reachable set");

  a_reach_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_bad_r |-> out_reach_r == (out_dist_r != spdg_pkg::DIST_INF))
    else $error("reachable flag disagrees with distance");

  a_mark_sets: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == spdg_pkg::ST_MARK |-> dist_we && dist_wdata[DB] && (dist_waddr == best_idx_r))
    else $error("picked node not marked visited");

  a_dist_write: assert property (@(posedge clk) disable iff (!rst_n)
    dist_we |-> state_r == spdg_pkg::ST_INIT || state_r == spdg_pkg::ST_RELAX ||
                state_r == spdg_pkg::ST_MARK)
    else $error("distance write outside init, mark or relax");

  a_round_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == spdg_pkg::ST_PICK || state_r == spdg_pkg::ST_RELAX |-> round_r < n_act)
    else $error("round count ran past node count");

endmodule
